// ===== hw/rtl/min_priority_message_queue_unit_assert.svh =====
// Assertion macros for the min-priority message queue.
`ifndef MIN_PRIORITY_MESSAGE_QUEUE_UNIT_ASSERT_SVH
`define MIN_PRIORITY_MESSAGE_QUEUE_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define MPQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that the antecedent implies the consequent in the same cycle.
`define MPQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the antecedent implies the consequent in the next cycle.
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mpq_pkg.sv =====
// Types and constants shared by the min-priority message queue.
package mpq_pkg;

  localparam int PRIO_W = 16;
  localparam int MSG_W  = 32;

  localparam logic MODE_PUT = 1'b0;
  localparam logic MODE_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_PUT_OK = 2'd0,
    ST_GOT    = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_INS,
    S_GRD,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/mpq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module mpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/min_priority_message_queue_unit.sv =====
// Min-priority message queue: sorted circular store in RAM with an insertion sequencer.
//
// Input channel (in_*): one item per handshake. in_tuser[0] is the mode (0 put,
// 1 get); in_tdata carries the priority and the payload handle of a put.
// Result channel (out_*): exactly one item per input item, in order. out_tuser
// holds the status (put accepted, get delivered, queue empty, queue full and put
// dropped); out_tdata carries the payload and priority of the removed entry,
// zero when none. Equal priorities leave in arrival order.
// Entries live in one RAM as a circular buffer kept sorted from the head. A get
// reads the head slot, then loads the result. A put walks back from the tail,
// comparing one stored entry per cycle and moving it one slot down while its
// priority is larger (up to DEPTH-1 entries moved), then writes the new entry.
// A put on a full store or a get on an empty store goes straight to the result
// state. in_tready rises again once the result sits in the output register.
// Reset empties the queue at once (head and count cleared, RAM untouched).
// When the receiver stalls, the result holds in the output register, and
// one further item may be worked on; its result then waits until the register frees.
module min_priority_message_queue_unit
  import mpq_pkg::*;
#(
  parameter int DEPTH        = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] priority_req, [47:16] payload
  input  logic [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] out_payload, [47:32] out_priority
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PB = PAYLOAD_BITS;
  localparam int EW = PRIO_W + PB;

  // Step a slot index around the ring.
  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic [AW-1:0]     rptr_r, rptr_nxt;
  logic [PRIO_W-1:0] req_prio_r, req_prio_nxt;
  logic [PB-1:0]     req_data_r, req_data_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [PB-1:0]     res_data_r, res_data_nxt;
  logic [PRIO_W-1:0] res_prio_r, res_prio_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [MSG_W-1:0]  out_payload_r, out_payload_nxt;
  logic [PRIO_W-1:0] out_prio_r, out_prio_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_wa, ram_ra;
  logic [EW-1:0]     ram_wd, ram_rd;

  logic              in_fire, out_free, is_empty, is_full, moves_back, last_pos;
  logic              in_mode;
  logic [PRIO_W-1:0] in_prio;
  logic [63:0]       in_wide;
  logic [63:0]       res_wide;
  logic [AW:0]       tail_sum;
  logic [AW-1:0]     tail_ptr;
  logic [PRIO_W-1:0] rd_prio;
  logic [PB-1:0]     rd_payload;

  mpq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign is_empty   = (count_r == '0);
  assign is_full    = (count_r == CW'(DEPTH));

  assign in_mode    = in_tuser[0];
  assign in_prio    = in_tdata[15:0];
  assign in_wide    = {32'd0, in_tdata[47:16]};
  assign res_wide   = 64'(res_data_r);

  // Physical slot just past the last entry; only used when not full.
  assign tail_sum   = {1'b0, head_r} + {1'b0, count_r[AW-1:0]};
  assign tail_ptr   = (tail_sum >= (AW + 1)'(DEPTH)) ?
                      AW'(tail_sum - (AW + 1)'(DEPTH)) : tail_sum[AW-1:0];

  assign rd_prio    = ram_rd[PRIO_W-1:0];
  assign rd_payload = ram_rd[PRIO_W +: PB];
  assign moves_back = (rd_prio > req_prio_r);
  assign last_pos   = (pos_r == AW'(1));

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_prio_r, out_payload_r};

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_mode == MODE_GET) begin
            state_nxt = is_empty ? S_DONE : S_GRD;
          end else if (is_full) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = is_empty ? S_INS : S_CMP;
          end
        end
      end
      S_CMP: begin
        if (moves_back) begin
          state_nxt = last_pos ? S_INS : S_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INS:   state_nxt = S_DONE;
      S_GRD:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, RAM controls and result register loads.
  always_comb begin
    count_nxt       = count_r;
    head_nxt        = head_r;
    pos_nxt         = pos_r;
    wptr_nxt        = wptr_r;
    rptr_nxt        = rptr_r;
    req_prio_nxt    = req_prio_r;
    req_data_nxt    = req_data_r;
    res_status_nxt  = res_status_r;
    res_data_nxt    = res_data_r;
    res_prio_nxt    = res_prio_r;
    out_tvalid_nxt  = out_tvalid_r;
    out_status_nxt  = out_status_r;
    out_payload_nxt = out_payload_r;
    out_prio_nxt    = out_prio_r;
    ram_we          = 1'b0;
    ram_wa          = wptr_r;
    ram_wd          = {req_data_r, req_prio_r};
    ram_re          = 1'b0;
    ram_ra          = head_r;

    // Drop the held result once the receiver takes it.
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_prio_nxt = in_prio;
          req_data_nxt = in_wide[PB-1:0];
          res_data_nxt = '0;
          res_prio_nxt = '0;
          if (in_mode == MODE_GET) begin
            res_status_nxt = is_empty ? ST_EMPTY : ST_GOT;
            ram_re         = !is_empty;
            ram_ra         = head_r;
          end else begin
            res_status_nxt = is_full ? ST_FULL : ST_PUT_OK;
            pos_nxt        = count_r[AW-1:0];
            wptr_nxt       = tail_ptr;
            rptr_nxt       = ptr_dec(tail_ptr);
            // Fetch the current last entry to start the backward walk.
            ram_re         = !is_full && !is_empty;
            ram_ra         = ptr_dec(tail_ptr);
          end
        end
      end
      S_CMP: begin
        ram_we = 1'b1;
        ram_wa = wptr_r;
        if (moves_back) begin
          // Move the larger entry one slot toward the tail and fetch the next unless the head entry was moved.
          ram_wd   = ram_rd;
          pos_nxt  = pos_r - 1'b1;
          wptr_nxt = rptr_r;
          if (!last_pos) begin
            ram_re   = 1'b1;
            ram_ra   = ptr_dec(rptr_r);
            rptr_nxt = ptr_dec(rptr_r);
          end
        end else begin
          ram_wd    = {req_data_r, req_prio_r};
          count_nxt = count_r + 1'b1;
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_wa    = wptr_r;
        ram_wd    = {req_data_r, req_prio_r};
        count_nxt = count_r + 1'b1;
      end
      S_GRD: begin
        res_data_nxt = rd_payload;
        res_prio_nxt = rd_prio;
        head_nxt     = ptr_inc(head_r);
        count_nxt    = count_r - 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt  = 1'b1;
          out_status_nxt  = res_status_r;
          out_payload_nxt = res_wide[MSG_W-1:0];
          out_prio_nxt    = res_prio_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      head_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      head_r       <= head_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    wptr_r        <= wptr_nxt;
    rptr_r        <= rptr_nxt;
    req_prio_r    <= req_prio_nxt;
    req_data_r    <= req_data_nxt;
    res_status_r  <= res_status_nxt;
    res_data_r    <= res_data_nxt;
    res_prio_r    <= res_prio_nxt;
    out_status_r  <= out_status_nxt;
    out_payload_r <= out_payload_nxt;
    out_prio_r    <= out_prio_nxt;
  end

`include "min_priority_message_queue_unit_assert.svh"

  `MPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "entry count above depth")
  `MPQ_ASSERT_IMPLY(a_walk_pos, state_r == S_CMP, pos_r != '0, "compare walk at head slot")
  `MPQ_ASSERT_NEXT(a_get_read, in_fire && in_mode == MODE_GET && !is_empty, state_r == S_GRD && count_r == $past(count_r), "get did not start head read")
  `MPQ_ASSERT_NEXT(a_count_step, 1'b1, count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 || count_r == $past(count_r) - 1'b1, "entry count jumped")

endmodule

// ===== test/tb_min_priority_message_queue_unit.sv =====
// Self-checking testbench for the min-priority message queue unit.
`timescale 1ns / 1ps

module tb_min_priority_message_queue_unit;
  import mpq_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int MSG_BITS    = 32;
  localparam logic [MSG_W-1:0] MSG_MASK = {MSG_W{1'b1}} >> (MSG_W - MSG_BITS);
  localparam int RANDOM_ITEMS = 1500;
  localparam int RUN_LIMIT    = 1_000_000;
  // a put may walk the whole store before it answers
  localparam int DRAIN_CYCLES = QUEUE_DEPTH + 40;

  typedef struct {
    logic             mode;
    logic [PRIO_W-1:0] prio;
    logic [MSG_W-1:0]  msg;
  } request_t;

  typedef struct {
    status_t          status;
    logic [MSG_W-1:0]  msg;
    logic [PRIO_W-1:0] prio;
  } reply_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [MSG_W-1:0]  msg;
  } entry_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [15:0] priority_req, [47:16] payload
  logic [0:0]  in_tuser;   // [0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [31:0] out_payload, [47:32] out_priority
  logic [1:0]  out_tuser;  // [1:0] status

  request_t request_q[$];    // items waiting to be driven
  reply_t   reply_q[$];      // replies owed by the block, oldest first
  entry_t   sorted_store[$]; // predicted contents, sorted by priority then arrival
  request_t cur_req;
  int       gen_fill;
  int       mismatch_count;
  int       cycle_count;
  int       burst_left;
  int       gap_left;
  int       stall_left;

  min_priority_message_queue_unit #(
    .DEPTH       (QUEUE_DEPTH),
    .PAYLOAD_BITS(MSG_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  // Work out the reply to one accepted item and advance the sorted store.
  task automatic predict_reply(input request_t req);
    reply_t rep;
    entry_t head;
    int     pos;
    rep.status = ST_PUT_OK;
    rep.msg    = '0;
    rep.prio   = '0;
    if (req.mode == MODE_PUT) begin
      if (sorted_store.size() >= QUEUE_DEPTH) begin
        rep.status = ST_FULL;
      end else begin
        // insert behind every entry of smaller or equal priority
        pos = sorted_store.size();
        while (pos > 0 && sorted_store[pos-1].prio > req.prio) pos--;
        sorted_store.insert(pos, '{prio: req.prio, msg: req.msg & MSG_MASK});
      end
    end else if (sorted_store.size() == 0) begin
      rep.status = ST_EMPTY;
    end else begin
      head       = sorted_store.pop_front();
      rep.status = ST_GOT;
      rep.msg    = head.msg;
      rep.prio   = head.prio;
    end
    reply_q.push_back(rep);
  endtask

  // Compare one accepted result item with the oldest owed reply.
  task automatic check_reply();
    reply_t exp;
    if (reply_q.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result item, actual status %0d data %h",
               $time, out_tuser, out_tdata);
    end else begin
      exp = reply_q.pop_front();
      if (out_tuser !== exp.status) begin
        mismatch_count++;
        $display("%0t: status expected %0d actual %0d", $time, exp.status, out_tuser);
      end
      if (out_tdata[31:0] !== exp.msg) begin
        mismatch_count++;
        $display("%0t: payload expected %h actual %h", $time, exp.msg, out_tdata[31:0]);
      end
      if (out_tdata[47:32] !== exp.prio) begin
        mismatch_count++;
        $display("%0t: priority expected %h actual %h", $time, exp.prio, out_tdata[47:32]);
      end
    end
  endtask

  task automatic add_put(input logic [PRIO_W-1:0] prio, input logic [MSG_W-1:0] msg);
    request_q.push_back('{mode: MODE_PUT, prio: prio, msg: msg});
    if (gen_fill < QUEUE_DEPTH) gen_fill++;
  endtask

  task automatic add_get();
    request_q.push_back('{mode: MODE_GET, prio: PRIO_W'($urandom), msg: $urandom});
    if (gen_fill > 0) gen_fill--;
  endtask

  // Mostly narrow priority ranges so that ties and long insert walks are common.
  function automatic logic [PRIO_W-1:0] pick_prio();
    case ($urandom_range(0, 3))
      0: pick_prio = PRIO_W'($urandom);
      1: pick_prio = PRIO_W'($urandom_range(0, 3));
      2: pick_prio = $urandom_range(0, 1) ? '1 : '0;
      default: pick_prio = PRIO_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Sender: bursts of items with gaps between them; quiet stretches have no gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_reply(cur_req);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_req.msg, cur_req.prio};
          in_tuser  <= cur_req.mode;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ((cycle_count / 3000) % 3 == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check results; stall in random runs, except in some long stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_reply();
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ((cycle_count / 2000) % 4 != 1 && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    int rand_items;
    int phase;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    cycle_count    = 0;
    mismatch_count = 0;
    gen_fill       = 0;
    burst_left     = 0;
    gap_left       = 0;
    stall_left     = 0;

    // directed: get on empty, field extremes, ties in arrival order, drain past empty
    add_get();
    add_put(16'h0000, 32'h0000_0000);
    add_put(16'hFFFF, 32'hFFFF_FFFF);
    add_put(16'h0005, 32'h0000_00A1);
    add_put(16'h0005, 32'h0000_00A2);
    add_put(16'h0005, 32'h0000_00A3);
    add_put(16'h0000, 32'h0000_0B01);
    add_put(16'hAAAA, 32'h5555_5555);
    add_put(16'h5555, 32'hAAAA_AAAA);
    repeat (9) add_get();

    // random: fill past full, drain past empty, or mix
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      phase = $urandom_range(0, 2);
      case (phase)
        0: n = QUEUE_DEPTH - gen_fill + $urandom_range(1, 4);
        1: n = gen_fill + $urandom_range(1, 4);
        default: n = $urandom_range(10, 60);
      endcase
      repeat (n) begin
        case (phase)
          0: if ($urandom_range(0, 9) == 0) add_get(); else add_put(pick_prio(), $urandom);
          1: if ($urandom_range(0, 9) == 0) add_put(pick_prio(), $urandom); else add_get();
          default: if ($urandom_range(0, 1) == 0) add_get(); else add_put(pick_prio(), $urandom);
        endcase
      end
      rand_items += n;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // hold until every item is sent and every owed reply has come back
    while (request_q.size() != 0 || in_tvalid || reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_ram.sv
hw/rtl/min_priority_message_queue_unit.sv
test/tb_min_priority_message_queue_unit.sv
